// ===== rtl/core/tvr_pkg.sv =====
// Shared types, constants and the TMDS byte decode for the TMDS video receiver.
package tvr_pkg;

   localparam int unsigned SYM_W   = 10;
   localparam int unsigned ADDR_W  = 24;
   localparam int unsigned COLOR_W = 24;
   localparam int unsigned DIM_W   = 13;
   localparam int unsigned BYTE_W  = 8;

   // Channel 0 control tokens
   localparam logic [SYM_W-1:0] TOKEN_NONE  = 10'h354;  // hsync 0, vsync 0
   localparam logic [SYM_W-1:0] TOKEN_HSYNC = 10'h0AB;  // hsync 1, vsync 0
   localparam logic [SYM_W-1:0] TOKEN_VSYNC = 10'h154;  // hsync 0, vsync 1
   localparam logic [SYM_W-1:0] TOKEN_BOTH  = 10'h2AB;  // hsync 1, vsync 1

   localparam logic [BYTE_W-1:0] XNOR_MASK = 8'hFE;

   localparam logic [1:0] FRAMES_SAT = 2'd2;

   localparam logic [DIM_W-1:0] RESET_WIDTH  = 13'd640;
   localparam logic [DIM_W-1:0] RESET_HEIGHT = 13'd480;

   typedef struct packed {
      logic               hsync;
      logic               vsync;
      logic               de;
      logic [COLOR_W-1:0] color;
   } tvr_sym_type;

   // Undo TMDS transition minimization: optional inversion, then XOR/XNOR chain.
   function automatic logic [BYTE_W-1:0] tvr_decode_byte(input logic [SYM_W-1:0] s);
      logic [SYM_W-1:0]  t;
      logic [BYTE_W-1:0] d;
      t = s;
      if (t[9]) begin
         t[7:0] = ~t[7:0];
      end
      d = t[7:0] ^ {t[6:0], 1'b0};
      if (!t[8]) begin
         d = d ^ XNOR_MASK;
      end
      return d;
   endfunction

endpackage

// ===== rtl/core/tvr_channels.sv =====
// Valid/ready channel interfaces for the symbol input and the pixel result.
interface tvr_req_if import tvr_pkg::*;;
   logic             valid;
   logic             ready;
   logic [SYM_W-1:0] symbol_ch0;
   logic [SYM_W-1:0] symbol_ch1;
   logic [SYM_W-1:0] symbol_ch2;

   modport source (output valid, output symbol_ch0, output symbol_ch1, output symbol_ch2,
                   input ready);
   modport sink   (input valid, input symbol_ch0, input symbol_ch1, input symbol_ch2,
                   output ready);
endinterface

interface tvr_rsp_if import tvr_pkg::*;;
   logic               valid;
   logic               ready;
   logic               pixel_valid;
   logic [ADDR_W-1:0]  pixel_addr;
   logic [COLOR_W-1:0] pixel_color;
   logic               line_end;
   logic               frame_end;
   logic [DIM_W-1:0]   measured_width;
   logic [DIM_W-1:0]   measured_height;
   logic               frames_ready;

   modport source (output valid, output pixel_valid, output pixel_addr, output pixel_color,
                   output line_end, output frame_end, output measured_width,
                   output measured_height, output frames_ready, input ready);
   modport sink   (input valid, input pixel_valid, input pixel_addr, input pixel_color,
                   input line_end, input frame_end, input measured_width,
                   input measured_height, input frames_ready, output ready);
endinterface

// ===== rtl/core/tvr_symbol_decode.sv =====
// Sync token match on channel 0 and byte decode of all three channels.
module tvr_symbol_decode import tvr_pkg::*; (
   input  logic [SYM_W-1:0] sym_ch0,
   input  logic [SYM_W-1:0] sym_ch1,
   input  logic [SYM_W-1:0] sym_ch2,
   output tvr_sym_type      sym_out
);

   always_comb begin
      sym_out.de    = 1'b0;
      sym_out.hsync = 1'b1;
      sym_out.vsync = 1'b1;
      case (sym_ch0)
         TOKEN_NONE: begin
            sym_out.hsync = 1'b0;
            sym_out.vsync = 1'b0;
         end
         TOKEN_HSYNC: begin
            sym_out.vsync = 1'b0;
         end
         TOKEN_VSYNC: begin
            sym_out.hsync = 1'b0;
         end
         TOKEN_BOTH: begin
            sym_out.de = 1'b0;
         end
         default: begin
            sym_out.de = 1'b1;  // not a token: active video
         end
      endcase
      sym_out.color = {tvr_decode_byte(sym_ch2), tvr_decode_byte(sym_ch1),
                       tvr_decode_byte(sym_ch0)};
   end

endmodule

// ===== rtl/core/tmds_video_receiver.sv =====
// Top level of the TMDS video receiver: timing recovery and pixel address generation.
//
// Each req word carries one pixel clock's three TMDS symbols; each one yields
// exactly one rsp word, in order. Throughput is one word per cycle while rsp
// is not stalled: a word sits in the input register, where the token match,
// byte decode, one 13x13 multiply for the address and the timing state update
// are done, and then lands in the result register, which drives rsp valid.
// While the result waits the input register still takes one more word; req
// ready only drops when both registers are full and rsp is stalled.
// Channel 0 tokens give hsync/vsync; any other channel 0 symbol is active
// video and produces a pixel at col + row * width (mod 2^24), color packed
// red:green:blue. A falling hsync while vsync is high closes a line and
// learns the width; both syncs low closes the frame and records the height.
// Column and row counters saturate at MAX_WIDTH and MAX_HEIGHT. The width
// and height reports are 13 bits wide. Reset is synchronous and leaves width
// 640, height 480.
module tmds_video_receiver import tvr_pkg::*; #(
   parameter int unsigned MAX_WIDTH  = 4096,
   parameter int unsigned MAX_HEIGHT = 4096
) (
   input  logic          clock,
   input  logic          reset,
   tvr_req_if.sink       req_chan,
   tvr_rsp_if.source     rsp_chan
);

   // counter widths hold the saturation value itself
   localparam int unsigned CW = $clog2(MAX_WIDTH + 1);
   localparam int unsigned RW = $clog2(MAX_HEIGHT + 1);
   // learned sizes also hold the reset values
   localparam int unsigned LW = (CW > 10) ? CW : 10;
   localparam int unsigned HW = (RW > 9) ? RW : 9;
   localparam int unsigned PW = RW + LW;

   localparam logic [CW-1:0] COL_MAX = CW'(MAX_WIDTH);
   localparam logic [RW-1:0] ROW_MAX = RW'(MAX_HEIGHT);

   // input register
   logic             in_valid_ff;
   logic [SYM_W-1:0] sym0_ff, sym1_ff, sym2_ff;

   // timing state
   logic          prev_hs_ff, prev_hs_in;
   logic [CW-1:0] col_ff, col_in;
   logic [RW-1:0] row_ff, row_in;
   logic          row_has_ff, row_has_in;
   logic [LW-1:0] width_ff, width_in;
   logic [HW-1:0] height_ff, height_in;
   logic [1:0]    frames_ff, frames_in;

   // result register
   logic               out_valid_ff;
   logic               pv_ff, pv_in;
   logic [ADDR_W-1:0]  addr_ff, addr_in;
   logic [COLOR_W-1:0] color_ff, color_in;
   logic               le_ff, le_in;
   logic               fe_ff, fe_in;

   logic        advance;
   tvr_sym_type sym;
   logic [PW-1:0] row_base;
   logic [31:0]   width_wide, height_wide;

   // result slot frees when empty or taken this cycle
   assign advance        = in_valid_ff && (!out_valid_ff || rsp_chan.ready);
   assign req_chan.ready = !in_valid_ff || advance;

   tvr_symbol_decode u_decode (
      .sym_ch0 (sym0_ff),
      .sym_ch1 (sym1_ff),
      .sym_ch2 (sym2_ff),
      .sym_out (sym)
   );

   assign row_base = PW'(row_ff) * PW'(width_ff);

   always_comb begin
      prev_hs_in = sym.hsync;
      col_in     = col_ff;
      row_in     = row_ff;
      row_has_in = row_has_ff;
      width_in   = width_ff;
      height_in  = height_ff;
      frames_in  = frames_ff;
      pv_in      = 1'b0;
      addr_in    = '0;
      color_in   = '0;
      le_in      = 1'b0;
      fe_in      = 1'b0;

      if (!sym.hsync && !sym.vsync) begin
         // frame close; an empty frame only rewinds the position
         if (row_ff != '0) begin
            height_in = HW'(row_ff);
            if (frames_ff != FRAMES_SAT) begin
               frames_in = frames_ff + 2'd1;
            end
            fe_in = 1'b1;
         end
         col_in = '0;
         row_in = '0;
      end else begin
         if (sym.de) begin
            pv_in      = 1'b1;
            addr_in    = ADDR_W'(row_base) + ADDR_W'(col_ff);
            color_in   = sym.color;
            row_has_in = 1'b1;
            if (col_ff < COL_MAX) begin
               col_in = col_ff + CW'(1);
            end
         end
         // falling hsync in vsync high: line close (never with active video)
         if (sym.vsync && !sym.hsync && prev_hs_ff) begin
            if (col_ff != '0 && LW'(col_ff) != width_ff) begin
               width_in = LW'(col_ff);
            end
            if (row_has_ff) begin
               if (row_ff < ROW_MAX) begin
                  row_in = row_ff + RW'(1);
               end
               row_has_in = 1'b0;
            end
            if (HW'(row_in) > height_ff) begin
               height_in = HW'(row_in);
            end
            col_in = '0;
            le_in  = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else if (req_chan.ready) begin
         in_valid_ff <= req_chan.valid;
      end
      if (req_chan.ready && req_chan.valid) begin
         sym0_ff <= req_chan.symbol_ch0;
         sym1_ff <= req_chan.symbol_ch1;
         sym2_ff <= req_chan.symbol_ch2;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         prev_hs_ff <= 1'b0;
         col_ff     <= '0;
         row_ff     <= '0;
         row_has_ff <= 1'b0;
         width_ff   <= LW'(RESET_WIDTH);
         height_ff  <= HW'(RESET_HEIGHT);
         frames_ff  <= '0;
      end else if (advance) begin
         prev_hs_ff <= prev_hs_in;
         col_ff     <= col_in;
         row_ff     <= row_in;
         row_has_ff <= row_has_in;
         width_ff   <= width_in;
         height_ff  <= height_in;
         frames_ff  <= frames_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else if (advance) begin
         out_valid_ff <= 1'b1;
      end else if (rsp_chan.ready) begin
         out_valid_ff <= 1'b0;
      end
      if (advance) begin
         pv_ff    <= pv_in;
         addr_ff  <= addr_in;
         color_ff <= color_in;
         le_ff    <= le_in;
         fe_ff    <= fe_in;
      end
   end

   // width, height and frame count are live state, valid with each word
   assign width_wide  = 32'(width_ff);
   assign height_wide = 32'(height_ff);

   assign rsp_chan.valid           = out_valid_ff;
   assign rsp_chan.pixel_valid     = pv_ff;
   assign rsp_chan.pixel_addr      = addr_ff;
   assign rsp_chan.pixel_color     = color_ff;
   assign rsp_chan.line_end        = le_ff;
   assign rsp_chan.frame_end       = fe_ff;
   assign rsp_chan.measured_width  = width_wide[DIM_W-1:0];
   assign rsp_chan.measured_height = height_wide[DIM_W-1:0];
   assign rsp_chan.frames_ready    = (frames_ff == FRAMES_SAT);

endmodule

// ===== rtl/core/tvr_checker.sv =====
// Port-level assertions for the TMDS video receiver and their bind.
module tvr_checker import tvr_pkg::*; (
   input logic               clock,
   input logic               reset,
   input logic               rsp_valid,
   input logic               rsp_ready,
   input logic               pixel_valid,
   input logic [ADDR_W-1:0]  pixel_addr,
   input logic [COLOR_W-1:0] pixel_color,
   input logic               line_end,
   input logic               frame_end,
   input logic               frames_ready
);

   // stalled word holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(pixel_valid) &&
         $stable(pixel_addr) && $stable(pixel_color) && $stable(line_end) &&
         $stable(frame_end))
      else $error("rsp word changed while stalled");

   // no word right after reset
   a_reset_idle: assert property (@(posedge clock)
      $past(reset) |-> !rsp_valid)
      else $error("rsp valid right after reset");

   // pixel, line close and frame close come from distinct sync states
   a_events_exclusive: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> !(pixel_valid && line_end) && !(pixel_valid && frame_end) &&
         !(line_end && frame_end))
      else $error("pixel, line end and frame end overlap");

   // a blank word carries zero address and color
   a_blank_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !pixel_valid |-> pixel_addr == '0 && pixel_color == '0)
      else $error("non-pixel word with address or color");

   // frames_ready never drops once shown
   a_ready_sticky: assert property (@(posedge clock) disable iff (reset)
      $past(rsp_valid) && $past(frames_ready) && !$past(reset) |-> frames_ready)
      else $error("frames_ready dropped");

endmodule

bind tmds_video_receiver tvr_checker u_tvr_checker (
   .clock        (clock),
   .reset        (reset),
   .rsp_valid    (rsp_chan.valid),
   .rsp_ready    (rsp_chan.ready),
   .pixel_valid  (rsp_chan.pixel_valid),
   .pixel_addr   (rsp_chan.pixel_addr),
   .pixel_color  (rsp_chan.pixel_color),
   .line_end     (rsp_chan.line_end),
   .frame_end    (rsp_chan.frame_end),
   .frames_ready (rsp_chan.frames_ready)
);
